// ----- design/array_linked_list_engine_assert.svh -----
// Assertion macros for the linked list engine.
// Needs a clock named clock and a reset named reset in the including scope.
`ifndef ARRAY_LINKED_LIST_ENGINE_ASSERT_SVH
`define ARRAY_LINKED_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define ALLE_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset
`define ALLE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/alle_pkg.sv -----
// Shared types and constants for the linked list engine.
// No dependencies.
package alle_pkg;

   localparam int NODE_DEPTH = 16;
   localparam int IDX_W      = $clog2(NODE_DEPTH);
   localparam int LINK_W     = $clog2(NODE_DEPTH + 1);
   localparam int RESULT_CAP = 16;
   localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(NODE_DEPTH);

   typedef enum logic [2:0] {
      OP_INS_FRONT = 3'd0,
      OP_INS_BACK  = 3'd1,
      OP_INS_AT    = 3'd2,
      OP_DELETE    = 3'd3,
      OP_FIND      = 3'd4,
      OP_READ      = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_NOTFOUND = 3'd2,
      ST_BADPOS   = 3'd3,
      ST_EMPTY    = 3'd4
   } status_type;

   typedef struct packed {
      logic [2:0] opcode;
      logic [7:0] value;
      logic [3:0] position;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] out_value;
      logic [4:0] match_count;
      logic       last;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE, S_CHECK, S_WALK, S_ALLOC, S_ATTACH, S_UNLINK, S_FREE
   } state_type;

   typedef enum logic [2:0] {
      DP_NOP, DP_LOAD, DP_ADVANCE, DP_ALLOC, DP_ATTACH, DP_UNLINK, DP_FREE
   } dp_op_type;

   typedef enum logic [1:0] {
      RK_PLAIN, RK_NODE, RK_HITS
   } rsp_kind_type;

   typedef struct packed {
      dp_op_type    op;
      logic         rsp_en;
      status_type   rsp_status;
      rsp_kind_type kind;
      logic         rsp_last;
   } cmd_type;

   typedef struct packed {
      logic [2:0] opcode;
      logic       free_nil;
      logic       list_nil;
      logic       pos_bad;
      logic       cur_nil;
      logic       at_pos;
      logic       val_match;
      logic       next_nil;
      logic       read_cap;
      logic       hits_zero;
   } sts_type;

endpackage

// ----- design/array_linked_list_engine.sv -----
// Linked list engine over a 16-node store with a free list.
// Walking opcodes visit up to 16 nodes, one per cycle via the single link read port.
// Read-out gives one result per cycle; a new request is taken only when idle.
// Synchronous reset empties the list and chains all nodes onto the free list.
// Results are shown for one cycle with rsp_strobe; the receiver cannot stall.
module array_linked_list_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  alle_pkg::req_type  req_data,
   output logic              rsp_strobe,
   output alle_pkg::rsp_type  rsp_data
);
   import alle_pkg::*;

   `include "array_linked_list_engine_assert.svh"

   cmd_type cmd;
   sts_type sts;

   alle_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   alle_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // A final result appears only once the engine is back to idle
   `ALLE_ASSERT_NOW(a_last_idle, rsp_strobe && rsp_data.last, !busy, "final result while busy")
   // An accepted request always starts work
   `ALLE_ASSERT_NEXT(a_start_busy, start && !busy, busy, "request accepted but not busy")
   // A read-out streams without gaps until its last node
   `ALLE_ASSERT_NEXT(a_read_stream, rsp_strobe && !rsp_data.last, rsp_strobe, "read-out gap")

endmodule

// ----- design/alle_ctrl.sv -----
// Controller state machine of the linked list engine.
// Depends on alle_pkg.
module alle_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  alle_pkg::sts_type sts,
   output alle_pkg::cmd_type cmd
);
   import alle_pkg::*;

   state_type state_ff, state_in;

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_CHECK;
         end
         S_CHECK: begin
            case (sts.opcode)
               OP_INS_FRONT: state_in = sts.free_nil ? S_IDLE : S_ALLOC;
               OP_INS_BACK:  state_in = sts.free_nil ? S_IDLE : S_WALK;
               OP_INS_AT:    state_in = (sts.pos_bad || sts.free_nil) ? S_IDLE : S_WALK;
               OP_DELETE, OP_FIND, OP_READ: state_in = sts.list_nil ? S_IDLE : S_WALK;
               default:      state_in = S_IDLE;
            endcase
         end
         S_WALK: begin
            case (sts.opcode)
               OP_INS_BACK: if (sts.cur_nil) state_in = S_ALLOC;
               OP_INS_AT:   if (sts.cur_nil || sts.at_pos) state_in = S_ALLOC;
               OP_DELETE: begin
                  if (sts.cur_nil) state_in = S_IDLE;
                  else if (sts.val_match) state_in = S_UNLINK;
               end
               OP_FIND:     if (sts.cur_nil) state_in = S_IDLE;
               OP_READ:     if (sts.next_nil || sts.read_cap) state_in = S_IDLE;
               default:     state_in = S_IDLE;
            endcase
         end
         S_ALLOC:  state_in = S_ATTACH;
         S_ATTACH: state_in = S_IDLE;
         S_UNLINK: state_in = S_FREE;
         S_FREE:   state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // Commands to the datapath
   always_comb begin
      cmd = '{op: DP_NOP, rsp_en: 1'b0, rsp_status: ST_OK, kind: RK_PLAIN, rsp_last: 1'b1};
      case (state_ff)
         S_IDLE: begin
            if (start) cmd.op = DP_LOAD;
         end
         S_CHECK: begin
            case (sts.opcode)
               OP_INS_FRONT, OP_INS_BACK: begin
                  if (sts.free_nil) begin
                     cmd.rsp_en = 1'b1;
                     cmd.rsp_status = ST_FULL;
                  end
               end
               OP_INS_AT: begin
                  if (sts.pos_bad) begin
                     cmd.rsp_en = 1'b1;
                     cmd.rsp_status = ST_BADPOS;
                  end else if (sts.free_nil) begin
                     cmd.rsp_en = 1'b1;
                     cmd.rsp_status = ST_FULL;
                  end
               end
               OP_DELETE, OP_FIND, OP_READ: begin
                  if (sts.list_nil) begin
                     cmd.rsp_en = 1'b1;
                     cmd.rsp_status = ST_EMPTY;
                  end
               end
               default: cmd.rsp_en = 1'b1;
            endcase
         end
         S_WALK: begin
            case (sts.opcode)
               OP_INS_BACK: if (!sts.cur_nil) cmd.op = DP_ADVANCE;
               OP_INS_AT:   if (!(sts.cur_nil || sts.at_pos)) cmd.op = DP_ADVANCE;
               OP_DELETE: begin
                  if (sts.cur_nil) begin
                     cmd.rsp_en = 1'b1;
                     cmd.rsp_status = ST_NOTFOUND;
                  end else if (!sts.val_match) begin
                     cmd.op = DP_ADVANCE;
                  end
               end
               OP_FIND: begin
                  if (sts.cur_nil) begin
                     cmd.rsp_en = 1'b1;
                     cmd.kind = RK_HITS;
                     cmd.rsp_status = sts.hits_zero ? ST_NOTFOUND : ST_OK;
                  end else begin
                     cmd.op = DP_ADVANCE;
                  end
               end
               OP_READ: begin
                  cmd.op = DP_ADVANCE;
                  cmd.rsp_en = 1'b1;
                  cmd.kind = RK_NODE;
                  cmd.rsp_last = sts.next_nil || sts.read_cap;
               end
               default: cmd.op = DP_NOP;
            endcase
         end
         S_ALLOC:  cmd.op = DP_ALLOC;
         S_ATTACH: begin
            cmd.op = DP_ATTACH;
            cmd.rsp_en = 1'b1;
         end
         S_UNLINK: cmd.op = DP_UNLINK;
         S_FREE: begin
            cmd.op = DP_FREE;
            cmd.rsp_en = 1'b1;
         end
         default: cmd.op = DP_NOP;
      endcase
   end

endmodule

// ----- design/alle_dp.sv -----
// Datapath of the linked list engine: node store, cursors, counters, result register.
// Depends on alle_pkg.
module alle_dp (
   input  logic              clock,
   input  logic              reset,
   input  alle_pkg::req_type  req_data,
   input  alle_pkg::cmd_type  cmd,
   output alle_pkg::sts_type  sts,
   output logic              rsp_strobe,
   output alle_pkg::rsp_type  rsp_data
);
   import alle_pkg::*;

   logic [7:0]        values_ff [NODE_DEPTH];
   logic [LINK_W-1:0] links_ff  [NODE_DEPTH];
   req_type           req_ff;
   logic [LINK_W-1:0] cur_ff, prev_ff, new_ff, steps_ff, count_ff;
   logic [LINK_W-1:0] list_head_ff, free_head_ff;
   logic [4:0]        hits_ff;
   logic              strobe_ff, strobe_in;
   rsp_type           rsp_ff, rsp_in;

   logic [IDX_W-1:0]  rd_idx, cur_idx, prev_idx, free_idx;
   logic [LINK_W-1:0] link_rd;
   logic [7:0]        val_rd;
   logic              match;

   // Single read port: free head during allocation, else the cursor
   assign cur_idx  = cur_ff[IDX_W-1:0];
   assign prev_idx = prev_ff[IDX_W-1:0];
   assign free_idx = free_head_ff[IDX_W-1:0];
   assign rd_idx   = (cmd.op == DP_ALLOC) ? free_idx : cur_idx;
   assign link_rd  = links_ff[rd_idx];
   assign val_rd   = values_ff[rd_idx];
   assign match    = (val_rd == req_ff.value);

   // Status to the controller
   always_comb begin
      sts.opcode    = req_ff.opcode;
      sts.free_nil  = (free_head_ff == NIL_LINK);
      sts.list_nil  = (list_head_ff == NIL_LINK);
      sts.pos_bad   = (LINK_W'(req_ff.position) > count_ff);
      sts.cur_nil   = (cur_ff == NIL_LINK);
      sts.at_pos    = (steps_ff == LINK_W'(req_ff.position));
      sts.val_match = match;
      sts.next_nil  = (link_rd == NIL_LINK);
      sts.read_cap  = (steps_ff == LINK_W'(RESULT_CAP - 1));
      sts.hits_zero = (hits_ff == 5'd0);
   end

   // Node values, written only on allocation; request register, loaded with each new request
   always_ff @(posedge clock) begin
      if (cmd.op == DP_ALLOC) values_ff[free_idx] <= req_ff.value;
      if (cmd.op == DP_LOAD) req_ff <= req_data;
   end

   // Links, heads, cursors and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NODE_DEPTH; i++) begin
            links_ff[i] <= LINK_W'(i + 1);
         end
         list_head_ff <= NIL_LINK;
         free_head_ff <= '0;
         count_ff     <= '0;
         cur_ff       <= NIL_LINK;
         prev_ff      <= NIL_LINK;
         new_ff       <= NIL_LINK;
         steps_ff     <= '0;
         hits_ff      <= '0;
      end else begin
         case (cmd.op)
            DP_LOAD: begin
               cur_ff   <= list_head_ff;
               prev_ff  <= NIL_LINK;
               steps_ff <= '0;
               hits_ff  <= '0;
            end
            DP_ADVANCE: begin
               prev_ff  <= cur_ff;
               cur_ff   <= link_rd;
               steps_ff <= steps_ff + 1'b1;
               if (match && hits_ff != 5'd31) hits_ff <= hits_ff + 1'b1;
            end
            DP_ALLOC: begin
               links_ff[free_idx] <= cur_ff;
               free_head_ff       <= link_rd;
               new_ff             <= free_head_ff;
               count_ff           <= count_ff + 1'b1;
            end
            DP_ATTACH: begin
               if (prev_ff == NIL_LINK) list_head_ff <= new_ff;
               else links_ff[prev_idx] <= new_ff;
            end
            DP_UNLINK: begin
               if (prev_ff == NIL_LINK) list_head_ff <= link_rd;
               else links_ff[prev_idx] <= link_rd;
            end
            DP_FREE: begin
               links_ff[cur_idx] <= free_head_ff;
               free_head_ff      <= cur_ff;
               if (count_ff != '0) count_ff <= count_ff - 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // Build the result
   always_comb begin
      strobe_in          = cmd.rsp_en;
      rsp_in.status      = cmd.rsp_status;
      rsp_in.out_value   = (cmd.kind == RK_NODE) ? val_rd : 8'd0;
      rsp_in.match_count = (cmd.kind == RK_HITS) ? hits_ff : 5'd0;
      rsp_in.last        = cmd.rsp_last;
   end

   // Register the result
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ----- tb/tb_array_linked_list_engine.sv -----
// Self-checking testbench for array_linked_list_engine: a directed table, then random traffic.
// Results are compared with a behavioral list model that keeps its own node store and free list.
// Depends on alle_pkg and the array_linked_list_engine RTL.
`timescale 1ns / 100ps

module tb_array_linked_list_engine;
   import alle_pkg::*;

   localparam logic [2:0] OP_SPARE_A = 3'd6;
   localparam logic [2:0] OP_SPARE_B = 3'd7;
   localparam logic [4:0] NULL_IDX   = 5'd16;
   localparam int         WATCH_MAX  = 2000;
   localparam int         DRAIN_WAIT = 40;
   localparam int         RAND_ITEMS = 140;
   localparam int         QUIET_TAIL = 30;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type rsp;
   } dir_row_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   // list model state
   logic [7:0] list_vals [16];
   logic [4:0] list_links [16];
   logic [4:0] list_head_q;
   logic [4:0] free_head_q;
   int         node_total;

   rsp_type     pending_rsp [$];
   dir_row_type dir_rows [$];
   int          fail_count;
   int          idle_cycles;

   array_linked_list_engine DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic rsp_type make_rsp(logic [2:0] st, logic [7:0] val, logic [4:0] cnt,
                                        logic fin);
      rsp_type r;
      r.status      = st;
      r.out_value   = val;
      r.match_count = cnt;
      r.last        = fin;
      return r;
   endfunction

   // Pop a node off the free list and fill it
   function automatic logic [4:0] grab_node(logic [7:0] v, logic [4:0] link);
      logic [4:0] n;
      n = free_head_q;
      free_head_q = list_links[n[3:0]];
      list_vals[n[3:0]] = v;
      list_links[n[3:0]] = link;
      node_total++;
      return n;
   endfunction

   function automatic void hook_after(logic [4:0] prev, logic [4:0] n);
      if (prev != NULL_IDX) list_links[prev[3:0]] = n;
      else list_head_q = n;
   endfunction

   // Apply one request to the list model and collect its results
   task automatic apply_list_op(input req_type r, ref rsp_type outs [$]);
      logic [4:0] prev, cur, nx;
      int         i, hits, k;
      prev = NULL_IDX;
      cur  = list_head_q;
      outs = {};
      case (r.opcode)
         OP_INS_FRONT: begin
            if (free_head_q == NULL_IDX) outs.push_back(make_rsp(ST_FULL, 0, 0, 1));
            else begin
               list_head_q = grab_node(r.value, list_head_q);
               outs.push_back(make_rsp(ST_OK, 0, 0, 1));
            end
         end
         OP_INS_BACK: begin
            if (free_head_q == NULL_IDX) outs.push_back(make_rsp(ST_FULL, 0, 0, 1));
            else begin
               while (cur != NULL_IDX) begin
                  prev = cur;
                  cur = list_links[cur[3:0]];
               end
               hook_after(prev, grab_node(r.value, NULL_IDX));
               outs.push_back(make_rsp(ST_OK, 0, 0, 1));
            end
         end
         OP_INS_AT: begin
            if (int'(r.position) > node_total) outs.push_back(make_rsp(ST_BADPOS, 0, 0, 1));
            else if (free_head_q == NULL_IDX) outs.push_back(make_rsp(ST_FULL, 0, 0, 1));
            else begin
               for (i = 0; i < int'(r.position) && cur != NULL_IDX; i++) begin
                  prev = cur;
                  cur = list_links[cur[3:0]];
               end
               hook_after(prev, grab_node(r.value, cur));
               outs.push_back(make_rsp(ST_OK, 0, 0, 1));
            end
         end
         OP_DELETE: begin
            if (list_head_q == NULL_IDX) outs.push_back(make_rsp(ST_EMPTY, 0, 0, 1));
            else begin
               while (cur != NULL_IDX && list_vals[cur[3:0]] != r.value) begin
                  prev = cur;
                  cur = list_links[cur[3:0]];
               end
               if (cur == NULL_IDX) outs.push_back(make_rsp(ST_NOTFOUND, 0, 0, 1));
               else begin
                  hook_after(prev, list_links[cur[3:0]]);
                  list_links[cur[3:0]] = free_head_q;
                  free_head_q = cur;
                  node_total--;
                  outs.push_back(make_rsp(ST_OK, 0, 0, 1));
               end
            end
         end
         OP_FIND: begin
            hits = 0;
            if (list_head_q == NULL_IDX) outs.push_back(make_rsp(ST_EMPTY, 0, 0, 1));
            else begin
               while (cur != NULL_IDX) begin
                  if (list_vals[cur[3:0]] == r.value && hits < 31) hits++;
                  cur = list_links[cur[3:0]];
               end
               outs.push_back(make_rsp(hits != 0 ? ST_OK : ST_NOTFOUND, 0, 5'(hits), 1));
            end
         end
         OP_READ: begin
            k = 0;
            if (list_head_q == NULL_IDX) outs.push_back(make_rsp(ST_EMPTY, 0, 0, 1));
            else begin
               while (cur != NULL_IDX && k < RESULT_CAP) begin
                  nx = list_links[cur[3:0]];
                  outs.push_back(make_rsp(ST_OK, list_vals[cur[3:0]], 0,
                                          nx == NULL_IDX || k == RESULT_CAP - 1));
                  k++;
                  cur = nx;
               end
            end
         end
         default: outs.push_back(make_rsp(ST_OK, 0, 0, 1));
      endcase
   endtask

   // Issue one request and wait for the handshake
   task automatic issue(input req_type r, input bit typed, input rsp_type typed_rsp);
      rsp_type outs [$];
      @(negedge clock);
      start    <= 1'b1;
      req_data <= r;
      while (busy) @(negedge clock);
      @(posedge clock);
      apply_list_op(r, outs);
      if (typed) pending_rsp.push_back(typed_rsp);
      else foreach (outs[j]) pending_rsp.push_back(outs[j]);
   endtask

   task automatic hold_off(int cycles);
      @(negedge clock);
      start <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   function automatic void add_row(logic [2:0] op, logic [7:0] v, logic [3:0] pos, bit typed,
                                   rsp_type exp_rsp);
      dir_row_type row;
      row.req.opcode   = op;
      row.req.value    = v;
      row.req.position = pos;
      row.typed        = typed;
      row.rsp          = exp_rsp;
      dir_rows.push_back(row);
   endfunction

   // Check each strobed result against the oldest expectation
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (reset) idle_cycles <= 0;
      else begin
         if (rsp_strobe || (start && !busy)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_strobe) begin
            if (pending_rsp.size() == 0) begin
               $error("unexpected result: %p", rsp_data);
               fail_count++;
            end else begin
               exp_rsp = pending_rsp.pop_front();
               if (rsp_data.status !== exp_rsp.status) begin
                  $error("status: expected %0d, actual %0d", exp_rsp.status, rsp_data.status);
                  fail_count++;
               end
               if (rsp_data.out_value !== exp_rsp.out_value) begin
                  $error("out_value: expected %0d, actual %0d", exp_rsp.out_value,
                         rsp_data.out_value);
                  fail_count++;
               end
               if (rsp_data.match_count !== exp_rsp.match_count) begin
                  $error("match_count: expected %0d, actual %0d", exp_rsp.match_count,
                         rsp_data.match_count);
                  fail_count++;
               end
               if (rsp_data.last !== exp_rsp.last) begin
                  $error("last: expected %0d, actual %0d", exp_rsp.last, rsp_data.last);
                  fail_count++;
               end
            end
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (idle_cycles >= WATCH_MAX) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      rsp_type    none;
      req_type    r;
      logic [7:0] vpool [4];
      bit         fill_mode;
      int         pick;
      none = make_rsp(ST_OK, 0, 0, 1);
      fail_count  = 0;
      idle_cycles = 0;
      start    = 1'b0;
      req_data = '0;
      reset    = 1'b1;
      for (int i = 0; i < 16; i++) begin
         list_vals[i]  = 8'd0;
         list_links[i] = 5'(i + 1);
      end
      list_head_q = NULL_IDX;
      free_head_q = 5'd0;
      node_total  = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty list cases, extremes, every opcode
      add_row(OP_READ,      8'h00, 4'd0,  1, make_rsp(ST_EMPTY, 0, 0, 1));
      add_row(OP_DELETE,    8'h00, 4'd0,  1, make_rsp(ST_EMPTY, 0, 0, 1));
      add_row(OP_FIND,      8'hFF, 4'd0,  1, make_rsp(ST_EMPTY, 0, 0, 1));
      add_row(OP_INS_AT,    8'h11, 4'd1,  1, make_rsp(ST_BADPOS, 0, 0, 1));
      add_row(OP_INS_AT,    8'h22, 4'd15, 1, make_rsp(ST_BADPOS, 0, 0, 1));
      add_row(OP_INS_AT,    8'h33, 4'd0,  0, none);
      add_row(OP_INS_FRONT, 8'h00, 4'd0,  1, make_rsp(ST_OK, 0, 0, 1));
      add_row(OP_INS_BACK,  8'hFF, 4'd15, 1, make_rsp(ST_OK, 0, 0, 1));
      add_row(OP_INS_AT,    8'hAA, 4'd1,  0, none);
      add_row(OP_INS_AT,    8'h55, 4'd4,  0, none);
      add_row(OP_READ,      8'h00, 4'd0,  0, none);
      add_row(OP_FIND,      8'hFF, 4'd0,  0, none);
      add_row(OP_FIND,      8'h12, 4'd0,  1, make_rsp(ST_NOTFOUND, 0, 0, 1));
      add_row(OP_DELETE,    8'h77, 4'd0,  1, make_rsp(ST_NOTFOUND, 0, 0, 1));
      add_row(OP_DELETE,    8'h00, 4'd0,  0, none);
      add_row(OP_INS_FRONT, 8'hFF, 4'd0,  0, none);
      add_row(OP_FIND,      8'hFF, 4'd0,  0, none);
      add_row(OP_DELETE,    8'hFF, 4'd0,  0, none);
      add_row(OP_READ,      8'h00, 4'd0,  0, none);
      add_row(OP_SPARE_A,   8'hFF, 4'd15, 1, make_rsp(ST_OK, 0, 0, 1));
      add_row(OP_SPARE_B,   8'h00, 4'd0,  1, make_rsp(ST_OK, 0, 0, 1));
      foreach (dir_rows[i]) issue(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);

      // random: alternate filling and draining phases over a small value pool
      fill_mode = 1'b1;
      for (int n = 0; n < RAND_ITEMS; n++) begin
         if (n % 20 == 0) begin
            fill_mode = (n % 40 == 0);
            foreach (vpool[j]) vpool[j] = 8'($urandom);
         end
         if (n == RAND_ITEMS / 2) begin
            // drop start, then let the block go fully quiet once
            hold_off(1);
            while (pending_rsp.size() != 0) @(posedge clock);
            hold_off(25);
         end
         pick = $urandom_range(0, 99);
         if (fill_mode) begin
            if (pick < 20) r.opcode = OP_INS_FRONT;
            else if (pick < 40) r.opcode = OP_INS_BACK;
            else if (pick < 60) r.opcode = OP_INS_AT;
            else if (pick < 70) r.opcode = OP_DELETE;
            else if (pick < 83) r.opcode = OP_FIND;
            else if (pick < 96) r.opcode = OP_READ;
            else r.opcode = pick[0] ? OP_SPARE_A : OP_SPARE_B;
         end else begin
            if (pick < 8) r.opcode = OP_INS_FRONT;
            else if (pick < 14) r.opcode = OP_INS_BACK;
            else if (pick < 20) r.opcode = OP_INS_AT;
            else if (pick < 65) r.opcode = OP_DELETE;
            else if (pick < 80) r.opcode = OP_FIND;
            else if (pick < 96) r.opcode = OP_READ;
            else r.opcode = pick[0] ? OP_SPARE_A : OP_SPARE_B;
         end
         r.value = ($urandom_range(0, 3) == 0) ? 8'($urandom) : vpool[$urandom_range(0, 3)];
         r.position = ($urandom_range(0, 4) == 0) ? 4'($urandom)
                    : 4'($urandom_range(0, node_total > 15 ? 15 : node_total));
         if (n < RAND_ITEMS - QUIET_TAIL && $urandom_range(0, 3) == 0)
            hold_off($urandom_range(1, 7));
         issue(r, 0, none);
      end
      @(negedge clock);
      start <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0 && pending_rsp.size() == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
